>>> rtl/core/ria_pkg.sv
// Package for the recycling index allocator.
// Holds payload structs, status codes, controller interface structs and defaults.
// No dependencies.
package ria_pkg;

    localparam int IDX_W           = 12;
    localparam int CFG_W           = 13;
    localparam int IDX_SPAN        = 4096;
    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_INDEX_LIMIT = 4096;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_QUEUE_FULL = 2'd2,
        ST_NULL_FREE  = 2'd3
    } ria_status_t;

    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] index;
        logic             index_is_null;
    } ria_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        ria_status_t      status;
    } ria_rsp_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop_load;
    } ria_cmd_t;

    typedef struct packed {
        logic pop_needed;
    } ria_sts_t;

endpackage

>>> rtl/core/ria_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the recycle queue storage. No package dependencies.
module ria_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ria_ctrl.sv
// Controller state machine of the recycling index allocator.
// Sequences accept, execute, queue read and result beat; uses ria_pkg.
module ria_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ria_pkg::ria_cmd_t cmd,
    input  ria_pkg::ria_sts_t sts
);
    import ria_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = sts.pop_needed ? S_POP : S_RESP;
            end
            S_POP: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_RESP);
    assign cmd.capture  = s_valid && (state_reg == S_IDLE);
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.pop_load = (state_reg == S_POP);

endmodule

>>> rtl/core/ria_dp.sv
// Datapath of the recycling index allocator: queue pointers, counters, limit register.
// Depends on ria_pkg and ria_ram.
module ria_dp #(
    parameter int MAX_ENTRIES = ria_pkg::DEF_MAX_ENTRIES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [ria_pkg::CFG_W-1:0]  cfg_wdata,
    input  ria_pkg::ria_req_t          s_data,
    output ria_pkg::ria_rsp_t          m_data,
    input  ria_pkg::ria_cmd_t          cmd,
    output ria_pkg::ria_sts_t          sts
);
    import ria_pkg::*;

    localparam int PTR_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_INT = (MAX_ENTRIES < IDX_SPAN) ? MAX_ENTRIES : IDX_SPAN;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_ENTRIES);
    localparam logic [CFG_W-1:0] FRESH_CAP = CFG_W'(CAP_INT);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CFG_W-1:0] high_water_reg, high_water_next;
    logic [CFG_W-1:0] index_limit_reg;
    ria_req_t         req_reg;
    ria_rsp_t         rsp_reg, rsp_next;

    logic             is_alloc;
    logic             q_empty;
    logic             q_full;
    logic [CFG_W-1:0] fresh_limit;
    logic             fresh_ok;
    logic             do_pop;
    logic             do_push;
    logic             do_fresh;
    logic [IDX_W-1:0] ram_rdata;

    assign is_alloc    = (req_reg.command == CMD_ALLOC);
    assign q_empty     = (count_reg == '0);
    assign q_full      = (count_reg == FULL_CNT);
    assign fresh_limit = (index_limit_reg > FRESH_CAP) ? FRESH_CAP : index_limit_reg;
    assign fresh_ok    = (high_water_reg < fresh_limit);

    assign do_pop   = cmd.exec && is_alloc && !q_empty;
    assign do_fresh = cmd.exec && is_alloc && q_empty && fresh_ok;
    assign do_push  = cmd.exec && !is_alloc && !req_reg.index_is_null && !q_full;

    assign sts.pop_needed = is_alloc && !q_empty;

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        high_water_next = high_water_reg;
        if (do_pop) begin
            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
        if (do_push) begin
            tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
        if (do_fresh) begin
            high_water_next = high_water_reg + CFG_W'(1);
        end
    end

    always_comb begin
        rsp_next = rsp_reg;
        if (cmd.exec) begin
            rsp_next.granted_index = '0;
            rsp_next.status        = ST_OK;
            if (is_alloc) begin
                if (q_empty) begin
                    if (fresh_ok) begin
                        rsp_next.granted_index = high_water_reg[IDX_W-1:0];
                    end else begin
                        rsp_next.status = ST_EXHAUSTED;
                    end
                end
            end else if (req_reg.index_is_null) begin
                rsp_next.status = ST_NULL_FREE;
            end else if (q_full) begin
                rsp_next.status = ST_QUEUE_FULL;
            end
        end else if (cmd.pop_load) begin
            rsp_next.granted_index = ram_rdata;
            rsp_next.status        = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            high_water_reg  <= '0;
            index_limit_reg <= CFG_W'(DEF_INDEX_LIMIT);
        end else begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            high_water_reg <= high_water_next;
            if (cfg_we) begin
                index_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        rsp_reg <= rsp_next;
    end

    ria_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTRIES)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (do_push),
        .waddr (tail_reg),
        .wdata (req_reg.index),
        .re    (do_pop),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign m_data = rsp_reg;

endmodule

>>> rtl/core/recycling_index_allocator.sv
// Recycling index allocator: one request in flight; the result beat follows the input
// beat after the controller's execute state, and after its queue-read state for the
// registered RAM read when the index comes from the recycle queue. A new request is
// accepted only once the result beat of the last one is taken, so an output stall
// holds the flow. Synchronous reset clears the queue pointers, count, high-water counter
// and sets the index limit to 4096; the queue RAM is not cleared and needs no clearing.
module recycling_index_allocator #(
    parameter int MAX_ENTRIES = ria_pkg::DEF_MAX_ENTRIES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ria_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ria_pkg::ria_req_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ria_pkg::ria_rsp_t         m_data
);
    import ria_pkg::*;

    ria_cmd_t cmd;
    ria_sts_t sts;

    assign cfg_ready = 1'b1;

    ria_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ria_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input accepted while a result beat is pending.");

    a_no_accept_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready && !m_valid)
        else $error("Request did not enter execution after its input beat.");

    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready && !m_valid)
        else $error("Block did not return to idle after a result beat.");

    a_zero_index_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |-> (m_data.granted_index == '0))
        else $error("Nonzero granted index with a non-ok status.");
`endif

endmodule
